/* hw/rtl/wsc_pkg.sv */
// shared types and constants for the wrench sensor conditioner
package wsc_pkg;

    localparam int AXES    = 6;
    localparam int DW      = 32;
    localparam int ENTRIES = AXES * AXES;
    localparam int AXW     = 3;
    localparam int IDXW    = 6;
    localparam int SUMW    = 48;
    localparam int DIVW    = 50;
    localparam int REMW    = 18;
    localparam int ACCW    = 67;
    localparam int GAINW   = 17;
    localparam int CNTW    = 16;
    localparam int IN_DW   = 232;
    localparam int OUT_DW  = 72;

    localparam logic [AXW-1:0]  LAST_AXIS = AXW'(AXES - 1);
    localparam logic [5:0]      DIV_LAST  = 6'(DIVW - 1);
    localparam logic [GAINW-1:0] GAIN_ONE  = 17'd65536;
    localparam logic [GAINW-1:0] GAIN_RST  = 17'd6554;
    localparam logic [CNTW-1:0]  CAL_RST   = 16'd200;

    localparam logic CFG_GAIN = 1'b0;
    localparam logic CFG_CAL  = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_LOWER  = 2'd2,
        OP_UPPER  = 2'd3
    } t_op;

    typedef struct packed {
        logic           load;
        logic           write_tbl;
        logic           cal_acc;
        logic           cnt_inc;
        logic           div_init;
        logic           div_step;
        logic           div_wr;
        logic           set_cal;
        logic           mac_issue;
        logic           f1;
        logic           f2;
        logic           f3;
        logic           freeze;
        logic           fault_upd;
        logic [AXW-1:0] axis;
        logic [AXW-1:0] col;
        logic [IDXW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic faulted;
        logic calibrated;
        logic cal_done;
    } t_stat;

endpackage

/* hw/rtl/wsc_datapath.sv */
// datapath: tables, calibration sums, serial divider, shared multiplier and filter
module wsc_datapath import wsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [GAINW-1:0]  i_cfg_wdata,
    input  logic [IN_DW-1:0]  i_in_tdata,
    input  logic [1:0]        i_in_tuser,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic [OUT_DW-1:0] o_out_tdata,
    output logic [3:0]        o_out_tuser
);

    function automatic logic signed [DW-1:0] sat32(input logic signed [ACCW-1:0] v);
        if (v > 67'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -67'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[DW-1:0];
        end
    endfunction

    logic [GAINW-1:0]       r_gain;
    logic [CNTW-1:0]        r_cal_n;
    t_op                    r_op;
    logic [IDXW-1:0]        r_idx;
    logic signed [DW-1:0]   r_val;
    logic signed [DW-1:0]   r_raw [AXES];
    logic                   r_calib_item;

    logic signed [DW-1:0]   r_coef_mem [ENTRIES];
    logic signed [DW-1:0]   r_lo [AXES];
    logic signed [DW-1:0]   r_hi [AXES];

    logic signed [SUMW-1:0] r_sum [AXES];
    logic signed [DW-1:0]   r_off [AXES];
    logic signed [DW-1:0]   r_filt [AXES];
    logic [CNTW-1:0]        r_cnt;
    logic                   r_calibrated;
    logic                   r_fault;

    logic signed [DW-1:0]   r_fv [AXES];
    logic signed [DW-1:0]   r_dv [AXES];
    logic [AXES-1:0]        r_oor;

    logic [DIVW-1:0]        r_dq;
    logic [REMW-1:0]        r_rem;
    logic                   r_neg;

    logic signed [DW-1:0]   r_coef;
    logic signed [DW-1:0]   r_dsel;
    logic                   r_v1;
    logic                   r_first1;
    logic signed [2*DW-1:0] r_prod;
    logic                   r_v2;
    logic                   r_first2;
    logic signed [ACCW-1:0] r_acc;
    logic signed [DW-1:0]   r_t;
    logic signed [DIVW:0]   r_gprod;

    logic [AXW-1:0]         a;
    logic [AXW-1:0]         c;
    logic [CNTW-1:0]        need;
    logic [GAINW-1:0]       g_eff;
    logic signed [DIVW-1:0] div_a;
    logic [DIVW-1:0]        div_mag;
    logic [REMW-1:0]        div_b;
    logic [REMW-1:0]        t_rem;
    logic                   ge;
    logic signed [DIVW-1:0] q;
    logic signed [DW:0]     dsub;
    logic signed [DW-1:0]   d;
    logic signed [ACCW-1:0] tq;
    logic signed [DW:0]     e;
    logic signed [DIVW:0]   fsh;
    logic signed [DW-1:0]   nf;
    logic signed [DW-1:0]   f_cur;
    logic                   oor_raw;
    logic                   oor_t;

    assign a     = i_cmd.axis;
    assign c     = i_cmd.col;
    assign f_cur = r_filt[a];
    assign need  = (r_cal_n == '0) ? CNTW'(1) : r_cal_n;
    assign g_eff = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;

    // offset = floor((2*sum + n) / (2*n)); negatives divide the complement
    assign div_a   = {r_sum[a][SUMW-1], r_sum[a], 1'b0} + {{(DIVW-CNTW){1'b0}}, r_cnt};
    assign div_mag = div_a[DIVW-1] ? ~div_a : div_a;
    assign div_b   = {1'b0, r_cnt, 1'b0};
    assign t_rem   = {r_rem[REMW-2:0], r_dq[DIVW-1]};
    assign ge      = (t_rem >= div_b);
    assign q       = r_neg ? ~r_dq : r_dq;

    assign dsub = {r_raw[c][DW-1], r_raw[c]} - {r_off[c][DW-1], r_off[c]};
    assign d    = sat32(ACCW'(dsub));

    assign tq  = (r_acc + 67'sd32768) >>> 16;
    assign e   = {r_t[DW-1], r_t} - {f_cur[DW-1], f_cur};
    assign fsh = ((r_gprod + 51'sd32768) >>> 16) + (DIVW+1)'(f_cur);
    assign nf  = sat32(ACCW'(fsh));

    assign oor_raw = (r_raw[a] < r_lo[a]) || (r_raw[a] > r_hi[a]);
    assign oor_t   = (r_t < r_lo[a]) || (r_t > r_hi[a]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RST;
            r_cal_n      <= CAL_RST;
            r_cnt        <= '0;
            r_calibrated <= 1'b0;
            r_fault      <= 1'b0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            for (int k = 0; k < AXES; k++) begin
                r_sum[k]  <= '0;
                r_off[k]  <= '0;
                r_filt[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_GAIN: r_gain  <= i_cfg_wdata;
                    CFG_CAL:  r_cal_n <= i_cfg_wdata[CNTW-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.cal_acc) begin
                r_sum[a] <= r_sum[a] + SUMW'(r_raw[a]);
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNTW'(1);
            end
            if (i_cmd.div_wr) begin
                r_off[a] <= sat32(ACCW'(q));
            end
            if (i_cmd.set_cal) begin
                r_calibrated <= 1'b1;
            end
            if (i_cmd.f3) begin
                r_filt[a] <= nf;
            end
            if (i_cmd.fault_upd) begin
                r_fault <= r_fault | (|r_oor);
            end
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    // payload and pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= t_op'(i_in_tuser);
            r_idx        <= i_in_tdata[IDXW-1:0];
            r_val        <= i_in_tdata[IDXW +: DW];
            r_calib_item <= ~r_calibrated;
            for (int k = 0; k < AXES; k++) begin
                r_raw[k] <= i_in_tdata[IDXW + DW + DW*k +: DW];
            end
        end
        if (i_cmd.div_init) begin
            r_dq  <= div_mag;
            r_rem <= '0;
            r_neg <= div_a[DIVW-1];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? (t_rem - div_b) : t_rem;
            r_dq  <= {r_dq[DIVW-2:0], ge};
        end
        if (i_cmd.mac_issue) begin
            r_dsel   <= d;
            r_first1 <= (c == '0);
        end
        r_prod   <= r_coef * r_dsel;
        r_first2 <= r_first1;
        if (r_v2) begin
            r_acc <= (r_first2 ? '0 : r_acc) + ACCW'(r_prod);
        end
        if (i_cmd.f1) begin
            r_t <= sat32(tq);
        end
        if (i_cmd.f2) begin
            r_gprod <= $signed({1'b0, g_eff}) * e;
        end
        if (i_cmd.cal_acc) begin
            r_fv[a]  <= r_filt[a];
            r_dv[a]  <= '0;
            r_oor[a] <= oor_raw;
        end
        if (i_cmd.f3) begin
            r_fv[a]  <= nf;
            r_dv[a]  <= sat32(ACCW'($signed({nf[DW-1], nf} - {f_cur[DW-1], f_cur})));
            r_oor[a] <= oor_t;
        end
        if (i_cmd.freeze) begin
            for (int k = 0; k < AXES; k++) begin
                r_fv[k] <= r_filt[k];
                r_dv[k] <= '0;
            end
            r_oor <= '0;
        end
    end

    // coefficient memory and limit tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_tbl) begin
            case (r_op)
                OP_COEF: begin
                    if (r_idx < IDXW'(ENTRIES)) begin
                        r_coef_mem[r_idx] <= r_val;
                    end
                end
                OP_LOWER: begin
                    if (r_idx < IDXW'(AXES)) begin
                        r_lo[r_idx[AXW-1:0]] <= r_val;
                    end
                end
                OP_UPPER: begin
                    if (r_idx < IDXW'(AXES)) begin
                        r_hi[r_idx[AXW-1:0]] <= r_val;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.mac_issue) begin
            r_coef <= r_coef_mem[i_cmd.addr];
        end
    end

    assign o_stat.op         = r_op;
    assign o_stat.faulted    = r_fault;
    assign o_stat.calibrated = r_calibrated;
    assign o_stat.cal_done   = (r_cnt >= need);

    assign o_out_tdata = {6'd0, r_fault, r_oor[a], r_dv[a], r_fv[a]};
    assign o_out_tuser = {r_calib_item, a};

endmodule

/* hw/rtl/wsc_ctrl.sv */
// controller: sequences calibration, division, matrix multiply, filter and output beats
module wsc_ctrl import wsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_tvalid,
    output logic  o_in_tready,
    output logic  o_out_tvalid,
    input  logic  i_out_tready,
    output logic  o_out_tlast,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DEC   = 14'b00000000000010,
        S_CAL   = 14'b00000000000100,
        S_DIVI  = 14'b00000000001000,
        S_DIVS  = 14'b00000000010000,
        S_DIVW  = 14'b00000000100000,
        S_ISSUE = 14'b00000001000000,
        S_DRAIN = 14'b00000010000000,
        S_F1    = 14'b00000100000000,
        S_F2    = 14'b00001000000000,
        S_F3    = 14'b00010000000000,
        S_FRZ   = 14'b00100000000000,
        S_FLT   = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } t_state;

    t_state          r_state, n_state;
    logic [AXW-1:0]  r_axis, n_axis;
    logic [AXW-1:0]  r_col, n_col;
    logic [IDXW-1:0] r_addr, n_addr;
    logic [5:0]      r_bit, n_bit;
    logic            r_drn, n_drn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= '0;
            r_col   <= '0;
            r_addr  <= '0;
            r_bit   <= '0;
            r_drn   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_col   <= n_col;
            r_addr  <= n_addr;
            r_bit   <= n_bit;
            r_drn   <= n_drn;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_axis       = r_axis;
        n_col        = r_col;
        n_addr       = r_addr;
        n_bit        = r_bit;
        n_drn        = r_drn;
        o_cmd        = '0;
        o_cmd.axis   = r_axis;
        o_cmd.col    = r_col;
        o_cmd.addr   = r_addr;
        o_in_tready  = 1'b0;
        o_out_tvalid = 1'b0;
        o_out_tlast  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_axis = '0;
                n_col  = '0;
                n_addr = '0;
                if (i_stat.op != OP_SAMPLE) begin
                    o_cmd.write_tbl = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_stat.faulted) begin
                    n_state = S_FRZ;
                end else if (!i_stat.calibrated) begin
                    n_state = S_CAL;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_CAL: begin
                o_cmd.cal_acc = 1'b1;
                o_cmd.cnt_inc = (r_axis == '0);
                if (r_axis == LAST_AXIS) begin
                    n_axis  = '0;
                    n_state = i_stat.cal_done ? S_DIVI : S_FLT;
                end else begin
                    n_axis = r_axis + AXW'(1);
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_bit          = '0;
                n_state        = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 6'd1;
                if (r_bit == DIV_LAST) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                o_cmd.div_wr = 1'b1;
                if (r_axis == LAST_AXIS) begin
                    o_cmd.set_cal = 1'b1;
                    n_axis        = '0;
                    n_state       = S_FLT;
                end else begin
                    n_axis  = r_axis + AXW'(1);
                    n_state = S_DIVI;
                end
            end
            S_ISSUE: begin
                o_cmd.mac_issue = 1'b1;
                n_addr          = r_addr + IDXW'(1);
                if (r_col == LAST_AXIS) begin
                    n_col   = '0;
                    n_drn   = 1'b0;
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + AXW'(1);
                end
            end
            S_DRAIN: begin
                // products still in flight through multiply and accumulate
                if (r_drn) begin
                    n_state = S_F1;
                end else begin
                    n_drn = 1'b1;
                end
            end
            S_F1: begin
                o_cmd.f1 = 1'b1;
                n_state  = S_F2;
            end
            S_F2: begin
                o_cmd.f2 = 1'b1;
                n_state  = S_F3;
            end
            S_F3: begin
                o_cmd.f3 = 1'b1;
                if (r_axis == LAST_AXIS) begin
                    n_axis  = '0;
                    n_state = S_FLT;
                end else begin
                    n_axis  = r_axis + AXW'(1);
                    n_state = S_ISSUE;
                end
            end
            S_FRZ: begin
                o_cmd.freeze = 1'b1;
                n_state      = S_FLT;
            end
            S_FLT: begin
                o_cmd.fault_upd = 1'b1;
                n_axis          = '0;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_out_tvalid = 1'b1;
                o_out_tlast  = (r_axis == LAST_AXIS);
                if (i_out_tready) begin
                    if (r_axis == LAST_AXIS) begin
                        n_axis  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_axis = r_axis + AXW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/wrench_sensor_conditioner.sv */
// top level of the six-axis wrench sensor conditioner
// Takes one beat at a time. A table-load beat is written after decode. A
// calibration sample accumulates the six axes, then 6 output beats go out; the
// sample that completes calibration also runs the bit-serial offset divider once
// per axis (one quotient bit per cycle). A conditioned sample runs one shared
// 32x32 multiplier through the 36 matrix entries a row at a time (6 issues, a
// pipeline drain, 3 filter steps per row), then the 6 result beats go out,
// each waiting through any output stall. A new beat is accepted only after
// the last result beat of the previous sample has been taken.
module wrench_sensor_conditioner import wsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [GAINW-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // entry_index, entry_value, force_x, force_y, force_z, torque_x, torque_y,
    // torque_z, zero pad
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // filtered_value, derivative, out_of_limit, fault, zero pad
    output logic [OUT_DW-1:0] m_axis_tdata,
    // axis, calibrating
    output logic [3:0]        m_axis_tuser,
    output logic              m_axis_tlast
);

    t_cmd  cmd;
    t_stat stat;

    wsc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .o_in_tready  (s_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_out_tlast  (m_axis_tlast),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    wsc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser)
    );

endmodule

/* tb/sv/wsc_checker.sv */
// scoreboard for the wrench sensor conditioner: predicts every result beat and compares
module wsc_checker import wsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [GAINW-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [IN_DW-1:0]  i_in_data,
    input  logic [1:0]        i_in_user,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [OUT_DW-1:0] i_out_data,
    input  logic [3:0]        i_out_user,
    input  logic              i_out_last,
    output int                o_pending,
    output int                o_errors
);

    typedef struct packed {
        logic [2:0]         axis;
        logic signed [31:0] fv;
        logic signed [31:0] dv;
        logic               oor;
        logic               calib;
        logic               fault;
        logic               last;
    } axis_res_t;

    axis_res_t  res_q[$];
    longint     coef[ENTRIES];
    longint     lo_lim[AXES];
    longint     hi_lim[AXES];
    longint     csum[AXES];
    longint     offs[AXES];
    longint     filt[AXES];
    int unsigned smp_cnt;
    bit         calibrated;
    bit         faulted;
    logic [GAINW-1:0] gain;
    logic [CNTW-1:0]  cal_n;
    int         errors;

    assign o_pending = res_q.size();
    assign o_errors  = errors;

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor division by a positive divisor
    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    task automatic condition_wrench(input logic [IN_DW-1:0] d);
        longint   raw[AXES];
        longint   fv[AXES];
        longint   dv[AXES];
        bit       oor[AXES];
        longint   dlt[AXES];
        longint   g, hi, lo, p, h, t, f, nf;
        int unsigned need;
        bit       calib;
        axis_res_t r;
        calib = !calibrated;
        for (int i = 0; i < AXES; i++) begin
            raw[i] = longint'($signed(d[38 + 32*i +: 32]));
            fv[i]  = filt[i];
            dv[i]  = 0;
            oor[i] = 0;
        end
        if (!faulted) begin
            if (calib) begin
                need = (cal_n == 0) ? 1 : cal_n;
                smp_cnt = (smp_cnt + 1) & 16'hFFFF;
                for (int i = 0; i < AXES; i++) begin
                    csum[i] += raw[i];
                    oor[i] = raw[i] < lo_lim[i] || raw[i] > hi_lim[i];
                end
                if (smp_cnt >= need) begin
                    for (int i = 0; i < AXES; i++)
                        offs[i] = sat32(fdiv(2*csum[i] + smp_cnt, 2*longint'(smp_cnt)));
                    calibrated = 1;
                end
            end else begin
                g = (gain > GAIN_ONE) ? 65536 : longint'(gain);
                for (int j = 0; j < AXES; j++) dlt[j] = sat32(raw[j] - offs[j]);
                for (int i = 0; i < AXES; i++) begin
                    hi = 0;
                    lo = 0;
                    for (int j = 0; j < AXES; j++) begin
                        p = coef[i*AXES + j] * dlt[j];
                        h = p >>> 16;
                        hi += h;
                        lo += p - h * 65536;
                    end
                    t  = sat32(hi + ((lo + 32768) >>> 16));
                    f  = filt[i];
                    nf = sat32(f + ((g * (t - f) + 32768) >>> 16));
                    filt[i] = nf;
                    fv[i] = nf;
                    dv[i] = sat32(nf - f);
                    oor[i] = t < lo_lim[i] || t > hi_lim[i];
                end
            end
            for (int i = 0; i < AXES; i++) if (oor[i]) faulted = 1;
        end
        for (int i = 0; i < AXES; i++) begin
            r.axis  = 3'(i);
            r.fv    = fv[i][31:0];
            r.dv    = dv[i][31:0];
            r.oor   = oor[i];
            r.calib = calib;
            r.fault = faulted;
            r.last  = (i == AXES - 1);
            res_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        logic [5:0]   idx;
        longint       val;
        axis_res_t    got;
        axis_res_t    exp_r;
        if (!i_rst_n) begin
            res_q.delete();
            foreach (csum[i]) begin
                csum[i] = 0;
                offs[i] = 0;
                filt[i] = 0;
            end
            smp_cnt    = 0;
            calibrated = 0;
            faulted    = 0;
            gain       = GAIN_RST;
            cal_n      = CAL_RST;
            errors     = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_GAIN) gain = i_cfg_wdata;
                else cal_n = i_cfg_wdata[CNTW-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                got.axis  = i_out_user[2:0];
                got.calib = i_out_user[3];
                got.fv    = i_out_data[31:0];
                got.dv    = i_out_data[63:32];
                got.oor   = i_out_data[64];
                got.fault = i_out_data[65];
                got.last  = i_out_last;
                if (res_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %p", got);
                end else begin
                    exp_r = res_q.pop_front();
                    if (got !== exp_r) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p got %p", exp_r, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                idx = i_in_data[5:0];
                val = longint'($signed(i_in_data[37:6]));
                case (t_op'(i_in_user))
                    OP_COEF:   if (idx < ENTRIES) coef[idx] = val;
                    OP_LOWER:  if (idx < AXES) lo_lim[idx] = val;
                    OP_UPPER:  if (idx < AXES) hi_lim[idx] = val;
                    default:   condition_wrench(i_in_data);
                endcase
            end
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// stimulus, reset and verdict for the wrench sensor conditioner testbench
module tb_top;
    import wsc_pkg::*;

    localparam int WDOG_LIMIT = 20000;
    localparam logic signed [31:0] VMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_addr;
    logic [GAINW-1:0]  i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata;
    logic [1:0]        s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_DW-1:0] m_axis_tdata;
    logic [3:0]        m_axis_tuser;
    logic              m_axis_tlast;

    int pending;
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    wrench_sensor_conditioner u_top (.*);

    wsc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(negedge i_clk) m_axis_tready = ($urandom_range(99) >= recv_stall_pct);

    // watchdog on cycles with no beat on either side
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("[wrench_sensor_conditioner] ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(4))
            0:       return VMAX;
            1:       return VMIN;
            2:       return 32'($signed($urandom_range(262143)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [191:0] rand_wrench();
        logic [191:0] w;
        for (int i = 0; i < AXES; i++) w[32*i +: 32] = rand_q16();
        return w;
    endfunction

    task automatic send_beat(input t_op op, input logic [5:0] idx,
                             input logic signed [31:0] val, input logic [191:0] wrench);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser  = op;
        s_axis_tdata  = {2'b00, wrench, val, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_sample(input logic [191:0] wrench);
        send_beat(OP_SAMPLE, 6'd0, 32'sd0, wrench);
    endtask

    // wait for every result, then for the divider or a table write to settle
    task automatic drain();
        s_axis_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic addr, input logic [GAINW-1:0] data);
        i_cfg_we    = 1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    initial begin
        int unsigned pick;
        i_rst_n        = 0;
        i_cfg_we       = 0;
        i_cfg_addr     = CFG_GAIN;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_SAMPLE;
        m_axis_tready  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // largest count first, lowered below the taken count later
        cfg_write(CFG_CAL, 17'd65535);
        cfg_write(CFG_GAIN, 17'd0);

        // limits wide open so no beat faults until the final phase
        for (int a = 0; a < AXES; a++) begin
            send_beat(OP_LOWER, 6'(a), VMIN, '0);
            send_beat(OP_UPPER, 6'(a), VMAX, '0);
        end
        for (int e = 0; e < ENTRIES; e++)
            send_beat(OP_COEF, 6'(e), (e % 7 == 0) ? 32'sh00010000 : rand_q16(), '0);
        // out-of-range writes are ignored
        send_beat(OP_COEF, 6'd36, VMAX, '0);
        send_beat(OP_COEF, 6'd63, VMIN, '0);
        send_beat(OP_LOWER, 6'd6, VMAX, '0);
        send_beat(OP_UPPER, 6'd63, VMIN, '0);

        // calibration samples at the extremes
        send_sample({6{VMAX}});
        send_sample({6{VMIN}});
        send_sample('0);
        send_sample({VMIN, VMAX, 32'sd1, -32'sd1, VMAX, VMIN});
        send_sample({3{32'sh00018000, -32'sh00008000}});
        drain();
        // zero count acts as one, so the next sample finishes calibration
        cfg_write(CFG_CAL, 17'd0);
        send_sample(rand_wrench());
        drain();

        cfg_write(CFG_GAIN, GAIN_ONE);
        send_sample({6{VMAX}});
        send_sample({6{VMIN}});
        send_sample('0);
        drain();
        // gain above one saturates
        cfg_write(CFG_GAIN, 17'h1FFFF);
        cfg_write(CFG_CAL, 17'h1FFFF);
        send_sample(rand_wrench());
        send_sample({6{VMIN}});
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            cfg_write(CFG_GAIN, (ph == 0) ? GAIN_RST : 17'($urandom_range(65536)));
            for (int n = 0; n < 15; n++) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    send_sample(rand_wrench());
                else if (pick < 95)
                    send_beat(OP_COEF, 6'($urandom), rand_q16(), rand_wrench());
                else if (pick < 98)
                    send_beat(OP_LOWER, 6'($urandom_range(7)), VMIN, rand_wrench());
                else
                    send_beat(OP_UPPER, 6'($urandom_range(7)), VMAX, rand_wrench());
            end
            drain();
        end

        // empty limit window forces a breach, then the block stays frozen
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_beat(OP_LOWER, 6'd1, 32'sd1, '0);
        send_beat(OP_UPPER, 6'd1, 32'sd0, '0);
        send_sample(rand_wrench());
        send_sample(rand_wrench());
        send_beat(OP_COEF, 6'd5, rand_q16(), '0);
        send_sample({6{VMAX}});
        drain();

        if (errors == 0 && pending == 0) begin
            $display("[wrench_sensor_conditioner] OK");
        end else begin
            $display("[wrench_sensor_conditioner] ERROR");
        end
        $finish;
    end

endmodule
